FILE: hdl/rpc_deadline_tracking_table_top_defines.svh
// Assertion helpers for the checker file of the outstanding-request table.
`ifndef RPC_DEADLINE_TRACKING_TABLE_TOP_DEFINES_SVH
`define RPC_DEADLINE_TRACKING_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RDT_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rdt_pkg.sv
`timescale 1ns / 1ps
package rdt_pkg;

    localparam int unsigned SLOTS_DEF   = 16;
    localparam int unsigned ID_BITS_DEF = 64;

    localparam logic [4:0]  SLOTS_RST     = 5'd16;
    localparam logic [63:0] RETENTION_RST = 64'd1000;

    typedef enum logic [2:0] {
        OP_REGISTER = 3'd0,
        OP_COMPLETE = 3'd1,
        OP_ABANDON  = 3'd2,
        OP_GET      = 3'd3,
        OP_RELEASE  = 3'd4,
        OP_SWEEP    = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_INVALID   = 4'd1,
        ST_FULL      = 4'd2,
        ST_EXISTS    = 4'd3,
        ST_CONFLICT  = 4'd4,
        ST_NOT_FOUND = 4'd5,
        ST_DONE      = 4'd6,
        ST_EXPIRED   = 4'd7,
        ST_AUTH      = 4'd8,
        ST_NOT_READY = 4'd9
    } t_status;

    typedef enum logic [1:0] {
        PH_PENDING   = 2'd0,
        PH_RESULT    = 2'd1,
        PH_STATUS    = 2'd2,
        PH_TIMED_OUT = 2'd3
    } t_phase;

    localparam logic [7:0] CFG_SLOTS     = 8'd0;
    localparam logic [7:0] CFG_RETENTION = 8'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ACT
    } t_state;

    // Result of the shared time unit.
    typedef struct packed {
        logic [63:0] sum;
        logic        ge_sum;
        logic        ge_a;
    } t_alu_res;

endpackage

FILE: hdl/rdt_alu.sv
`timescale 1ns / 1ps
module rdt_alu (
    input  logic [63:0]        i_a,
    input  logic [63:0]        i_b,
    input  logic [63:0]        i_now,
    output rdt_pkg::t_alu_res  o_res
);
    import rdt_pkg::*;

    logic [64:0] w_sum;
    logic [63:0] w_sat;

    // Saturating add of a time and a retention, compared against the current time.
    assign w_sum = {1'b0, i_a} + {1'b0, i_b};
    assign w_sat = w_sum[64] ? '1 : w_sum[63:0];

    always_comb begin
        o_res.sum    = w_sat;
        o_res.ge_sum = (i_now >= w_sat);
        o_res.ge_a   = (i_now >= i_a);
    end
endmodule

FILE: hdl/rdt_mem.sv
`timescale 1ns / 1ps
module rdt_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4,
    parameter int unsigned W     = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/rpc_deadline_tracking_table_top.sv
`timescale 1ns / 1ps
// Outstanding-request table with deadlines and timed retention.
// Requests arrive as beats on the slave stream (tdata carries the ids, digest,
// node, deadline and current time; tuser carries the request type and the
// response kind). Each request beat produces exactly one result beat on the
// master stream: status and entry state in tuser, the fields found by a get and
// the number of entries freed by the sweep in tdata.
// The table is held in a single-port-write, single-port-read memory and every
// request that passes the field checks walks the slots in use one per cycle
// through a shared saturating adder and comparator, matching in the same pass
// and, for register, complete, get and sweep, also sweeping; requests that fail
// the field checks skip the walk and go straight to the final step. The slave
// side is not ready while a request is in progress, so a new request is taken
// only once the result of the last one has gone into the output register.
// A result waits in the output register while the receiver stalls; the next
// request may be accepted meanwhile, but it finishes only once that register
// has been drained.
// Configuration beats (slots_in_use, retention_ms) are taken only while the
// block is idle. Reset clears all valid bits, restores the configuration
// defaults and empties the output register.
module rpc_deadline_tracking_table_top #(
    parameter int unsigned SLOTS   = rdt_pkg::SLOTS_DEF,
    parameter int unsigned ID_BITS = rdt_pkg::ID_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Request stream.
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // command id, correlation id, request digest, node id, deadline, current time
    input  logic [383:0] i_s_tdata,
    // req_type, response_kind
    input  logic [4:0]   i_s_tuser,
    // Result stream.
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // found command id, found digest, found node id, found deadline,
    // removed_count, zero padding
    output logic [263:0] o_m_tdata,
    // status, entry_state
    output logic [5:0]   o_m_tuser,
    // Configuration writes.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);
    import rdt_pkg::*;

    localparam int unsigned CW = $clog2(SLOTS + 1);
    localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef struct packed {
        logic [1:0]         phase;
        logic [63:0]        expiry;
        logic [ID_BITS-1:0] cmd;
        logic [ID_BITS-1:0] corr;
        logic [ID_BITS-1:0] dig;
        logic [ID_BITS-1:0] node;
        logic [63:0]        deadline;
    } t_rec;

    localparam int unsigned RW = $bits(t_rec);

    // Configuration.
    logic [4:0]  r_slots;
    logic [63:0] r_ret;

    // Sequencer.
    t_state r_state, n_state;

    // Latched request.
    logic [2:0]         r_op;
    logic [1:0]         r_kind;
    logic [ID_BITS-1:0] r_cmd, r_corr, r_dig, r_node;
    logic [63:0]        r_dl, r_now;
    logic               r_sweep;
    logic               r_inv;

    // Scan pipeline.
    logic [CW-1:0] r_idx;
    logic          r_pv;
    logic [AW-1:0] r_pidx;
    logic          r_valid [SLOTS];

    // Scan results.
    logic          r_hit, r_fhit;
    logic [AW-1:0] r_hidx, r_fidx;
    t_rec          r_hrec;
    logic [CW-1:0] r_removed;

    // Output register.
    logic        r_ovalid;
    logic [3:0]  r_ostatus;
    logic [1:0]  r_oestate;
    logic [63:0] r_ocmd, r_odig, r_onode, r_odl;
    logic [4:0]  r_oremoved;

    // Input fields.
    logic               w_acc;
    logic [2:0]         w_in_op;
    logic [1:0]         w_in_kind;
    logic [ID_BITS-1:0] w_in_cmd, w_in_corr, w_in_dig, w_in_node;
    logic [63:0]        w_in_dl, w_in_now;
    logic               w_inv, w_sw;

    assign w_acc     = i_s_tvalid && o_s_tready;
    assign w_in_op   = i_s_tuser[2:0];
    assign w_in_kind = i_s_tuser[4:3];
    assign w_in_cmd  = i_s_tdata[0   +: ID_BITS];
    assign w_in_corr = i_s_tdata[64  +: ID_BITS];
    assign w_in_dig  = i_s_tdata[128 +: ID_BITS];
    assign w_in_node = i_s_tdata[192 +: ID_BITS];
    assign w_in_dl   = i_s_tdata[319:256];
    assign w_in_now  = i_s_tdata[383:320];

    // Field checks decide up front whether the request is rejected without a sweep.
    always_comb begin
        w_inv = 1'b1;
        w_sw  = 1'b0;
        unique case (w_in_op)
            OP_REGISTER: begin
                w_inv = (w_in_cmd == '0) || (w_in_corr == '0) || (w_in_dig == '0) ||
                        (w_in_node == '0) || (w_in_dl <= w_in_now);
                w_sw  = 1'b1;
            end
            OP_COMPLETE: begin
                w_inv = (w_in_kind > 2'd1);
                w_sw  = 1'b1;
            end
            OP_ABANDON: begin
                w_inv = (w_in_cmd == '0) || (w_in_corr == '0) || (w_in_dig == '0) ||
                        (w_in_node == '0) || (w_in_dl == '0);
            end
            OP_GET: begin
                w_inv = (w_in_corr == '0);
                w_sw  = 1'b1;
            end
            OP_RELEASE: begin
                w_inv = (w_in_corr == '0);
            end
            OP_SWEEP: begin
                w_inv = 1'b0;
                w_sw  = 1'b1;
            end
            default: begin
                w_inv = 1'b1;
            end
        endcase
    end

    // Number of slots scanned: the configured count, capped at the table size.
    logic [CW-1:0] w_n;
    always_comb begin
        if (int'(r_slots) > int'(SLOTS)) begin
            w_n = CW'(SLOTS);
        end else begin
            w_n = CW'(r_slots);
        end
    end

    logic w_issue;
    assign w_issue = (r_state == S_SCAN) && (r_idx < w_n);

    // Table memory.
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_rec          w_wdata, w_rd;
    logic [RW-1:0] w_rd_raw;

    rdt_mem #(
        .DEPTH (SLOTS),
        .AW    (AW),
        .W     (RW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rd_raw)
    );

    assign w_rd = t_rec'(w_rd_raw);

    // Shared time unit: deadline + retention while scanning, now + retention on
    // completion.
    t_alu_res    w_alu;
    logic [63:0] w_alu_a;

    assign w_alu_a = (r_state == S_ACT) ? r_now : w_rd.deadline;

    rdt_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (r_ret),
        .i_now (r_now),
        .o_res (w_alu)
    );

    // Evaluation of the slot read in the previous cycle.
    logic        w_v, w_to, w_exp_ok, w_free, w_v2, w_match;
    logic [1:0]  w_ph;
    logic [63:0] w_ex;
    t_rec        w_rec2;

    always_comb begin
        w_v      = r_pv && r_valid[r_pidx];
        w_to     = r_sweep && w_v && (w_rd.phase == PH_PENDING) && w_alu.ge_a;
        w_ph     = w_to ? PH_TIMED_OUT : w_rd.phase;
        w_ex     = w_to ? w_alu.sum : w_rd.expiry;
        w_exp_ok = w_to ? w_alu.ge_sum : (r_now >= w_rd.expiry);
        w_free   = r_sweep && w_v && (w_ph != PH_PENDING) && w_exp_ok;
        w_v2     = w_v && !w_free;
        if (r_op == OP_REGISTER) begin
            w_match = w_v2 && ((w_rd.cmd == r_cmd) || (w_rd.corr == r_corr));
        end else begin
            w_match = w_v2 && (r_corr != '0) && (w_rd.corr == r_corr);
        end
        w_rec2        = w_rd;
        w_rec2.phase  = w_ph;
        w_rec2.expiry = w_ex;
    end

    // Final step: decide the status and apply the single table update.
    logic    w_act_go, w_bind;
    t_status w_status;
    logic    a_we, a_set, a_clr, a_get;
    t_rec    a_wrec;
    logic [AW-1:0] a_widx;

    assign w_act_go = (r_state == S_ACT) && (!r_ovalid || i_m_tready);
    assign w_bind   = (r_hrec.cmd == r_cmd) && (r_hrec.corr == r_corr) &&
                      (r_hrec.dig == r_dig) && (r_hrec.node == r_node) &&
                      (r_hrec.deadline == r_dl);

    always_comb begin
        w_status = ST_INVALID;
        a_we     = 1'b0;
        a_set    = 1'b0;
        a_clr    = 1'b0;
        a_get    = 1'b0;
        a_wrec   = r_hrec;
        a_widx   = r_hidx;
        if (!r_inv) begin
            unique case (r_op)
                OP_REGISTER: begin
                    if (r_hit) begin
                        w_status = w_bind ? ST_EXISTS : ST_CONFLICT;
                    end else if (!r_fhit) begin
                        w_status = ST_FULL;
                    end else begin
                        w_status        = ST_OK;
                        a_we            = 1'b1;
                        a_set           = 1'b1;
                        a_widx          = r_fidx;
                        a_wrec.phase    = PH_PENDING;
                        a_wrec.expiry   = '0;
                        a_wrec.cmd      = r_cmd;
                        a_wrec.corr     = r_corr;
                        a_wrec.dig      = r_dig;
                        a_wrec.node     = r_node;
                        a_wrec.deadline = r_dl;
                    end
                end
                OP_COMPLETE: begin
                    if (!r_hit) begin
                        w_status = ST_NOT_FOUND;
                    end else if (r_hrec.phase == PH_TIMED_OUT) begin
                        w_status = ST_EXPIRED;
                    end else if (r_hrec.phase != PH_PENDING) begin
                        w_status = ST_DONE;
                    end else if ((r_hrec.cmd != r_cmd) || (r_hrec.dig != r_dig) ||
                                 (r_hrec.node != r_node)) begin
                        w_status = ST_AUTH;
                    end else begin
                        w_status      = ST_OK;
                        a_we          = 1'b1;
                        a_wrec.phase  = r_kind[0] ? PH_STATUS : PH_RESULT;
                        a_wrec.expiry = w_alu.sum;
                    end
                end
                OP_ABANDON: begin
                    if (!r_hit) begin
                        w_status = ST_NOT_FOUND;
                    end else if (!w_bind) begin
                        w_status = ST_CONFLICT;
                    end else if (r_hrec.phase != PH_PENDING) begin
                        w_status = ST_DONE;
                    end else begin
                        w_status = ST_OK;
                        a_clr    = 1'b1;
                    end
                end
                OP_GET: begin
                    if (!r_hit) begin
                        w_status = ST_NOT_FOUND;
                    end else begin
                        w_status = ST_OK;
                        a_get    = 1'b1;
                    end
                end
                OP_RELEASE: begin
                    if (!r_hit) begin
                        w_status = ST_NOT_FOUND;
                    end else if (r_hrec.phase == PH_PENDING) begin
                        w_status = ST_NOT_READY;
                    end else begin
                        w_status = ST_OK;
                        a_clr    = 1'b1;
                    end
                end
                OP_SWEEP: begin
                    w_status = ST_OK;
                end
                default: begin
                    w_status = ST_INVALID;
                end
            endcase
        end
    end

    // Memory write port: sweep write-back while scanning, the final update after.
    always_comb begin
        if (r_state == S_ACT) begin
            w_we    = w_act_go && a_we;
            w_waddr = a_widx;
            w_wdata = a_wrec;
        end else begin
            w_we    = w_to;
            w_waddr = r_pidx;
            w_wdata = w_rec2;
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = w_inv ? S_ACT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!w_issue && !r_pv) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                if (w_act_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request latch and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv      <= 1'b0;
            r_hit     <= 1'b0;
            r_fhit    <= 1'b0;
            r_idx     <= '0;
            r_removed <= '0;
            r_inv     <= 1'b0;
            r_sweep   <= 1'b0;
        end else begin
            r_pv <= w_issue;
            if (w_acc) begin
                r_op      <= w_in_op;
                r_kind    <= w_in_kind;
                r_cmd     <= w_in_cmd;
                r_corr    <= w_in_corr;
                r_dig     <= w_in_dig;
                r_node    <= w_in_node;
                r_dl      <= w_in_dl;
                r_now     <= w_in_now;
                r_inv     <= w_inv;
                r_sweep   <= w_sw;
                r_idx     <= '0;
                r_hit     <= 1'b0;
                r_fhit    <= 1'b0;
                r_removed <= '0;
            end else begin
                if (w_issue) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (w_match && !r_hit) begin
                    r_hit  <= 1'b1;
                    r_hidx <= r_pidx;
                    r_hrec <= w_rec2;
                end
                if (r_pv && !w_v2 && !r_fhit) begin
                    r_fhit <= 1'b1;
                    r_fidx <= r_pidx;
                end
                if (w_free) begin
                    r_removed <= r_removed + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_idx[AW-1:0];
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < int'(SLOTS); i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (w_free) begin
                r_valid[r_pidx] <= 1'b0;
            end
            if (w_act_go && a_set) begin
                r_valid[r_fidx] <= 1'b1;
            end
            if (w_act_go && a_clr) begin
                r_valid[r_hidx] <= 1'b0;
            end
        end
    end

    // Configuration registers, written only between requests.
    assign o_cfg_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= SLOTS_RST;
            r_ret   <= RETENTION_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SLOTS:     r_slots <= i_cfg_data[4:0];
                CFG_RETENTION: r_ret   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_act_go) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_act_go) begin
            r_ostatus  <= w_status;
            r_oremoved <= 5'(r_removed);
            if (a_get) begin
                r_oestate <= r_hrec.phase;
                r_ocmd    <= 64'(r_hrec.cmd);
                r_odig    <= 64'(r_hrec.dig);
                r_onode   <= 64'(r_hrec.node);
                r_odl     <= r_hrec.deadline;
            end else begin
                r_oestate <= '0;
                r_ocmd    <= '0;
                r_odig    <= '0;
                r_onode   <= '0;
                r_odl     <= '0;
            end
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {3'b000, r_oremoved, r_odl, r_onode, r_odig, r_ocmd};
    assign o_m_tuser  = {r_oestate, r_ostatus};
endmodule

FILE: hdl/rdt_chk.sv
`timescale 1ns / 1ps
`include "rpc_deadline_tracking_table_top_defines.svh"
module rdt_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [383:0] i_s_tdata,
    input logic [4:0]   i_s_tuser,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [263:0] o_m_tdata,
    input logic [5:0]   o_m_tuser,
    input logic         i_cfg_valid,
    input logic         o_cfg_ready,
    input logic [7:0]   i_cfg_index,
    input logic [63:0]  i_cfg_data
);
    import rdt_pkg::*;

    // A stalled result must hold.
    `RDT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result changed")

    // Once a request is taken the block is busy for at least the next cycle.
    `RDT_ASSERT_NXT(a_busy, i_clk, i_rst_n, i_s_tvalid && o_s_tready,
        !o_s_tready, "request accepted while busy")

    // Only a successful get carries entry state and stored fields.
    `RDT_ASSERT_IMP(a_fields_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser[3:0] != ST_OK),
        (o_m_tdata[255:0] == '0) && (o_m_tuser[5:4] == 2'b00), "fields set on failure")

    // A rejected request runs no sweep.
    `RDT_ASSERT_IMP(a_invalid_nosweep, i_clk, i_rst_n,
        o_m_tvalid && (o_m_tuser[3:0] == ST_INVALID),
        o_m_tdata[260:256] == 5'd0, "sweep on invalid request")
endmodule

bind rpc_deadline_tracking_table_top rdt_chk u_rdt_chk (.*);

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;
    import rdt_pkg::*;

    // Request types that the block must reject as unknown.
    localparam logic [2:0] OP_UNKNOWN_A = 3'd6;
    localparam logic [2:0] OP_UNKNOWN_B = 3'd7;
    localparam logic [1:0] KIND_RESULT  = 2'd0;
    localparam logic [1:0] KIND_STATUS  = 2'd1;
    localparam logic [1:0] KIND_BAD_A   = 2'd2;
    localparam logic [1:0] KIND_BAD_B   = 2'd3;
    localparam logic [63:0] MAX64       = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int NSLOT                = 16;
    localparam int POOL                 = 20;
    localparam int CYCLE_LIMIT          = 600000;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] cmd;
        logic [63:0] corr;
        logic [63:0] dig;
        logic [63:0] node;
        logic [63:0] dl;
        logic [63:0] now;
        logic [1:0]  kind;
    } req_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [1:0]  phase;
        logic [63:0] cmd;
        logic [63:0] dig;
        logic [63:0] node;
        logic [63:0] dl;
        logic [4:0]  removed;
    } answer_t;

    typedef struct packed {
        req_t        req;
        logic        typed;
        logic [3:0]  status;
        logic [4:0]  removed;
    } row_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [383:0] i_s_tdata = '0;
    logic [4:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [263:0] o_m_tdata;
    logic [5:0]   o_m_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_index = '0;
    logic [63:0]  i_cfg_data = '0;

    rpc_deadline_tracking_table_top i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the table and its configuration.
    logic        tbl_valid [NSLOT];
    t_phase      tbl_phase [NSLOT];
    logic [63:0] tbl_expiry [NSLOT];
    logic [63:0] tbl_cmd [NSLOT];
    logic [63:0] tbl_corr [NSLOT];
    logic [63:0] tbl_dig [NSLOT];
    logic [63:0] tbl_node [NSLOT];
    logic [63:0] tbl_dl [NSLOT];
    logic [4:0]  cfg_slots = SLOTS_RST;
    logic [63:0] cfg_retention = RETENTION_RST;

    answer_t answer_q[$];
    int      s_idle = 0;
    int      r_idle = 0;
    int      mismatches = 0;
    int      results_seen = 0;
    int      items_sent = 0;
    int      cfg_writes = 0;
    int      cycles = 0;

    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? MAX64 : s[63:0];
    endfunction

    function automatic int live_slots();
        return (cfg_slots > NSLOT) ? NSLOT : int'(cfg_slots);
    endfunction

    // Times out overdue pending entries, then frees finished entries past expiry.
    function automatic logic [4:0] sweep_table(input logic [63:0] now);
        logic [4:0] freed;
        freed = '0;
        for (int i = 0; i < live_slots(); i++) begin
            if (!tbl_valid[i]) continue;
            if (tbl_phase[i] == PH_PENDING && now >= tbl_dl[i]) begin
                tbl_phase[i]  = PH_TIMED_OUT;
                tbl_expiry[i] = sat_sum(tbl_dl[i], cfg_retention);
            end
            if (tbl_phase[i] != PH_PENDING && now >= tbl_expiry[i]) begin
                tbl_valid[i] = 1'b0;
                freed++;
            end
        end
        return freed;
    endfunction

    function automatic int slot_of(input logic [63:0] corr);
        for (int i = 0; i < live_slots(); i++)
            if (tbl_valid[i] && tbl_corr[i] == corr) return i;
        return -1;
    endfunction

    function automatic logic same_entry(input int i, input req_t r);
        return tbl_cmd[i] == r.cmd && tbl_corr[i] == r.corr && tbl_dig[i] == r.dig &&
               tbl_node[i] == r.node && tbl_dl[i] == r.dl;
    endfunction

    function automatic answer_t table_answer(input req_t r);
        answer_t a;
        int s;
        int free_i;
        a = '0;
        a.status = ST_INVALID;
        case (r.op)
            OP_REGISTER: begin
                if (r.cmd != 0 && r.corr != 0 && r.dig != 0 && r.node != 0 && r.dl > r.now) begin
                    a.removed = sweep_table(r.now);
                    a.status = ST_OK;
                    free_i = -1;
                    for (int i = 0; i < live_slots(); i++) begin
                        if (!tbl_valid[i]) begin
                            if (free_i < 0) free_i = i;
                            continue;
                        end
                        if (tbl_cmd[i] != r.cmd && tbl_corr[i] != r.corr) continue;
                        a.status = same_entry(i, r) ? ST_EXISTS : ST_CONFLICT;
                        break;
                    end
                    if (a.status == ST_OK && free_i < 0) a.status = ST_FULL;
                    if (a.status == ST_OK) begin
                        tbl_valid[free_i] = 1'b1;
                        tbl_phase[free_i] = PH_PENDING;
                        tbl_expiry[free_i] = '0;
                        tbl_cmd[free_i] = r.cmd;
                        tbl_corr[free_i] = r.corr;
                        tbl_dig[free_i] = r.dig;
                        tbl_node[free_i] = r.node;
                        tbl_dl[free_i] = r.dl;
                    end
                end
            end
            OP_COMPLETE: begin
                if (r.kind <= KIND_STATUS) begin
                    a.removed = sweep_table(r.now);
                    s = (r.corr == 0) ? -1 : slot_of(r.corr);
                    if (s < 0) a.status = ST_NOT_FOUND;
                    else if (tbl_phase[s] == PH_TIMED_OUT) a.status = ST_EXPIRED;
                    else if (tbl_phase[s] != PH_PENDING) a.status = ST_DONE;
                    else if (tbl_cmd[s] != r.cmd || tbl_dig[s] != r.dig || tbl_node[s] != r.node)
                        a.status = ST_AUTH;
                    else begin
                        tbl_phase[s] = (r.kind == KIND_RESULT) ? PH_RESULT : PH_STATUS;
                        tbl_expiry[s] = sat_sum(r.now, cfg_retention);
                        a.status = ST_OK;
                    end
                end
            end
            OP_ABANDON: begin
                if (r.cmd != 0 && r.corr != 0 && r.dig != 0 && r.node != 0 && r.dl != 0) begin
                    s = slot_of(r.corr);
                    if (s < 0) a.status = ST_NOT_FOUND;
                    else if (!same_entry(s, r)) a.status = ST_CONFLICT;
                    else if (tbl_phase[s] != PH_PENDING) a.status = ST_DONE;
                    else begin
                        tbl_valid[s] = 1'b0;
                        a.status = ST_OK;
                    end
                end
            end
            OP_GET: begin
                if (r.corr != 0) begin
                    a.removed = sweep_table(r.now);
                    s = slot_of(r.corr);
                    if (s < 0) a.status = ST_NOT_FOUND;
                    else begin
                        a.status = ST_OK;
                        a.phase = tbl_phase[s];
                        a.cmd = tbl_cmd[s];
                        a.dig = tbl_dig[s];
                        a.node = tbl_node[s];
                        a.dl = tbl_dl[s];
                    end
                end
            end
            OP_RELEASE: begin
                if (r.corr != 0) begin
                    s = slot_of(r.corr);
                    if (s < 0) a.status = ST_NOT_FOUND;
                    else if (tbl_phase[s] == PH_PENDING) a.status = ST_NOT_READY;
                    else begin
                        tbl_valid[s] = 1'b0;
                        a.status = ST_OK;
                    end
                end
            end
            OP_SWEEP: begin
                a.removed = sweep_table(r.now);
                a.status = ST_OK;
            end
            default: ;
        endcase
        return a;
    endfunction

    // Offers one request beat; the expectation is formed at the accepting edge.
    task automatic send_request(input row_t row);
        answer_t a;
        while ($urandom_range(99) < s_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {row.req.now, row.req.dl, row.req.node, row.req.dig, row.req.corr,
                      row.req.cmd};
        i_s_tuser <= {row.req.kind, row.req.op};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        a = table_answer(row.req);
        if (row.typed) begin
            a.status = row.status;
            a.removed = row.removed;
        end
        answer_q.push_back(a);
        items_sent++;
    endtask

    // Holds the beat until taken, then drops it before returning.
    task automatic write_cfg(input logic [7:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SLOTS) cfg_slots = val[4:0];
        else cfg_retention = val;
        cfg_writes++;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // One long hold-off of the result side, counted here in cycles.
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (!hold_done && results_seen == 60) begin
            hold_done <= 1'b1;
            hold_left <= 400;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result side: checks each beat and applies random back-pressure and the long hold-off.
    always @(posedge i_clk) begin
        answer_t e;
        answer_t got;
        cycles <= cycles + 1;
        if (o_m_tvalid && i_m_tready) begin
            got = '{o_m_tuser[3:0], o_m_tuser[5:4], o_m_tdata[63:0], o_m_tdata[127:64],
                    o_m_tdata[191:128], o_m_tdata[255:192], o_m_tdata[260:256]};
            results_seen <= results_seen + 1;
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                mismatches <= mismatches + 1;
            end else begin
                e = answer_q.pop_front();
                if (got !== e) begin
                    $display("%0t: result mismatch", $time);
                    $display("  expected st=%0d ph=%0d cmd=%h dig=%h node=%h dl=%h rm=%0d",
                             e.status, e.phase, e.cmd, e.dig, e.node, e.dl, e.removed);
                    $display("  actual   st=%0d ph=%0d cmd=%h dig=%h node=%h dl=%h rm=%0d",
                             got.status, got.phase, got.cmd, got.dig, got.node, got.dl,
                             got.removed);
                    mismatches <= mismatches + 1;
                end
            end
        end
        if ((!hold_done && results_seen == 60) || hold_left > 0) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= r_idle);
        end
    end

    always @(posedge i_clk) begin
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Random request pool: a small set of bindings so that lookups hit.
    logic [63:0] pool_cmd [POOL];
    logic [63:0] pool_corr [POOL];
    logic [63:0] pool_dig [POOL];
    logic [63:0] pool_node [POOL];
    logic [63:0] pool_dl [POOL];

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic row_t random_row(inout logic [63:0] clock_ms);
        row_t row;
        int k;
        int pick;
        row = '0;
        clock_ms = clock_ms + $urandom_range(0, 30);
        k = $urandom_range(POOL - 1);
        pick = $urandom_range(99);
        row.req.cmd = pool_cmd[k];
        row.req.corr = pool_corr[k];
        row.req.dig = pool_dig[k];
        row.req.node = pool_node[k];
        row.req.now = clock_ms;
        row.req.kind = ($urandom_range(19) == 0) ? 2'(KIND_BAD_A + $urandom_range(1))
                                                : 2'(KIND_RESULT + $urandom_range(1));
        if (pick < 30) begin
            row.req.op = OP_REGISTER;
            if (pool_dl[k] <= clock_ms || $urandom_range(1) == 0)
                pool_dl[k] = clock_ms + $urandom_range(1, 150);
            row.req.dl = pool_dl[k];
        end else if (pick < 50) row.req.op = OP_COMPLETE;
        else if (pick < 58) begin
            row.req.op = OP_ABANDON;
            row.req.dl = pool_dl[k];
        end else if (pick < 78) row.req.op = OP_GET;
        else if (pick < 90) row.req.op = OP_RELEASE;
        else if (pick < 96) row.req.op = OP_SWEEP;
        else begin
            // Noise: any type, fully random content.
            row.req.cmd = rand64();
            row.req.corr = rand64();
            row.req.dig = rand64();
            row.req.node = rand64();
            row.req.dl = rand64();
            row.req.now = rand64();
            row.req.kind = 2'($urandom_range(3));
            row.req.op = ($urandom_range(1) == 0) ? 3'(OP_UNKNOWN_A + $urandom_range(1))
                                                  : 3'($urandom_range(5));
        end
        // Occasionally disturb one field to reach the conflict, auth and invalid paths.
        if (pick < 96 && $urandom_range(9) == 0) begin
            case ($urandom_range(4))
                0: row.req.cmd ^= 64'd1 << $urandom_range(63);
                1: row.req.dig = '0;
                2: row.req.node ^= 64'd1 << $urandom_range(63);
                3: row.req.dl = row.req.dl + 1;
                default: row.req.corr = '0;
            endcase
        end
        return row;
    endfunction

    row_t table_rows[$];

    task automatic add_row(input logic [2:0] op, input logic [63:0] cmd, input logic [63:0] corr,
                           input logic [63:0] dig, input logic [63:0] node,
                           input logic [63:0] dl, input logic [63:0] now, input logic [1:0] kind,
                           input logic typed, input t_status st);
        table_rows.push_back('{'{op, cmd, corr, dig, node, dl, now, kind}, typed, st, 5'd0});
    endtask

    initial begin
        logic [63:0] clock_ms;
        logic [63:0] cfg_set [4][2];
        int per_phase;

        for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
        for (int i = 0; i < POOL; i++) begin
            pool_cmd[i] = rand64() | 64'd1;
            pool_corr[i] = rand64() | 64'd1;
            pool_dig[i] = rand64() | 64'd1;
            pool_node[i] = rand64() | 64'd1;
            pool_dl[i] = '0;
        end

        // Directed part: rows with a typed status are plain to read off the rules.
        add_row(OP_GET, 1, 64'hA, 3, 4, 0, 0, KIND_RESULT, 1, ST_NOT_FOUND);
        add_row(OP_REGISTER, 0, 64'hA, 3, 4, 100, 0, KIND_RESULT, 1, ST_INVALID);
        add_row(OP_REGISTER, 1, 64'hA, 3, 4, 100, 100, KIND_RESULT, 1, ST_INVALID);
        add_row(OP_REGISTER, 1, 64'hA, 3, 4, 100, 0, KIND_RESULT, 1, ST_OK);
        add_row(OP_REGISTER, 1, 64'hA, 3, 4, 100, 0, KIND_RESULT, 1, ST_EXISTS);
        add_row(OP_REGISTER, 1, 64'hA, 9, 4, 100, 0, KIND_RESULT, 1, ST_CONFLICT);
        add_row(OP_COMPLETE, 1, 64'hA, 3, 4, 0, 5, KIND_BAD_A, 1, ST_INVALID);
        add_row(OP_COMPLETE, 1, 64'hA, 3, 4, 0, 5, KIND_BAD_B, 1, ST_INVALID);
        add_row(OP_COMPLETE, 1, 64'hA, 3, 7, 0, 10, KIND_RESULT, 1, ST_AUTH);
        add_row(OP_GET, 0, 64'hA, 0, 0, 0, 10, KIND_RESULT, 0, ST_OK);
        add_row(OP_COMPLETE, 1, 64'hA, 3, 4, 0, 20, KIND_STATUS, 1, ST_OK);
        add_row(OP_COMPLETE, 1, 64'hA, 3, 4, 0, 21, KIND_RESULT, 1, ST_DONE);
        add_row(OP_RELEASE, 0, 64'hA, 0, 0, 0, 0, KIND_RESULT, 1, ST_OK);
        add_row(OP_REGISTER, 2, 64'hB, 5, 6, 50, 20, KIND_RESULT, 1, ST_OK);
        add_row(OP_RELEASE, 0, 64'hB, 0, 0, 0, 0, KIND_RESULT, 1, ST_NOT_READY);
        add_row(OP_GET, 0, 64'hB, 0, 0, 0, 60, KIND_RESULT, 0, ST_OK);
        add_row(OP_COMPLETE, 2, 64'hB, 5, 6, 0, 61, KIND_RESULT, 0, ST_OK);
        add_row(OP_RELEASE, 0, 0, 0, 0, 0, 0, KIND_RESULT, 1, ST_INVALID);
        add_row(OP_REGISTER, MAX64, MAX64, MAX64, MAX64, MAX64, MAX64 - 1, KIND_RESULT, 0,
                ST_OK);
        add_row(OP_ABANDON, MAX64, MAX64, MAX64, MAX64, 5, 0, KIND_RESULT, 1, ST_CONFLICT);
        add_row(OP_ABANDON, MAX64, MAX64, MAX64, MAX64, 0, 0, KIND_RESULT, 1, ST_INVALID);
        add_row(OP_ABANDON, MAX64, MAX64, MAX64, MAX64, MAX64, 0, KIND_RESULT, 1, ST_OK);
        add_row(OP_UNKNOWN_A, 1, 1, 1, 1, 1, 0, KIND_RESULT, 1, ST_INVALID);
        add_row(OP_UNKNOWN_B, 1, 1, 1, 1, 1, 0, KIND_RESULT, 1, ST_INVALID);
        add_row(OP_SWEEP, 0, 0, 0, 0, 0, MAX64, KIND_RESULT, 0, ST_OK);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        s_idle = 12;
        r_idle = 77;
        foreach (table_rows[i]) send_request(table_rows[i]);
        drain();

        // Settings per random phase: slot count and retention, extremes included.
        cfg_set = '{'{64'd16, 64'd1000}, '{64'd1, MAX64}, '{64'd16, 64'd1},
                    '{64'd7, 64'd200}};
        per_phase = 132;
        for (int p = 0; p < 4; p++) begin
            s_idle = (p == 0) ? 12 : (p == 1) ? 77 : 0;
            r_idle = (p == 0) ? 77 : (p == 1) ? 12 : 0;
            write_cfg(CFG_SLOTS, cfg_set[p][0]);
            write_cfg(CFG_RETENTION, cfg_set[p][1]);
            clock_ms = 64'd1000 * p;
            for (int n = 0; n < per_phase; n++) send_request(random_row(clock_ms));
            drain();
        end

        $display("Sent %0d requests, checked %0d results, %0d configuration writes,",
                 items_sent, results_seen, cfg_writes);
        $display("covering every request type, slot counts 1 to 16 and retention 1 to max.");
        if (mismatches == 0 && answer_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
